### design/lp_pkg.sv
// ----------------------------------------------------------------------------
// lp_pkg: shared constants and types of the line parameter pipeline
// Fixed-point formats, unit latencies, the CORDIC angle table and the
// structs that carry an item's side information down the pipeline.
// ----------------------------------------------------------------------------
package lp_pkg;

  // Coordinate format: signed Q16.16 in 32 bits.
  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  // Point differences need one bit more than a coordinate.
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int LEN_W       = COORD_WIDTH + 1;
  localparam int ANGLE_W     = FRAC_BITS + 10;

  // CORDIC datapath: 64-bit vectors normalized up to bit 59.
  localparam int CORDIC_STEPS = 33;
  localparam int CW           = 64;
  localparam int NORM_MSB     = 59;
  // Angle accumulator in units of 1e-9 degree.
  localparam int Z_W          = 40;
  localparam logic signed [Z_W-1:0] NDEG_90      = 40'sd90000000000;
  localparam logic        [29:0]    NDEG_PER_DEG = 30'd1000000000;
  // Quotient bits of the degree conversion (270 degrees fits below 2^(FRAC_BITS+9)).
  localparam int ANG_QBITS = FRAC_BITS + 9;

  // Latencies of the units, in cycles.
  localparam int DIV_LAT = COORD_WIDTH + 2;
  localparam int LEN_LAT = COORD_WIDTH + 5;
  localparam int ANG_LAT = 4 + CORDIC_STEPS + 2 + ANG_QBITS + 1;

  // arctan(2^-i) in 1e-9 degree.
  localparam logic signed [Z_W-1:0] ATAN_NDEG [CORDIC_STEPS] = '{
    40'sd45000000000, 40'sd26565051177, 40'sd14036243468, 40'sd7125016349,
    40'sd3576334375,  40'sd1789910608,  40'sd895173710,   40'sd447614171,
    40'sd223810500,   40'sd111905677,   40'sd55952892,    40'sd27976453,
    40'sd13988227,    40'sd6994114,     40'sd3497057,     40'sd1748528,
    40'sd874264,      40'sd437132,      40'sd218566,      40'sd109283,
    40'sd54642,       40'sd27321,       40'sd13660,       40'sd6830,
    40'sd3415,        40'sd1708,        40'sd854,         40'sd427,
    40'sd213,         40'sd107,         40'sd53,          40'sd27,
    40'sd13
  };

  // Input item with its decoded mode, carried alongside the divider.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;
    logic signed [COORD_WIDTH-1:0] x2;
    logic signed [COORD_WIDTH-1:0] y2;
    logic signed [COORD_WIDTH-1:0] gs;
    logic                          pslope;
    logic                          vert;
  } lp_side_t;

  // Finished line fields, carried alongside the length and angle units.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] slope;
    logic signed [COORD_WIDTH-1:0] icpt;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic                          vert;
  } lp_res_t;

endpackage

### design/lp_delay.sv
// ----------------------------------------------------------------------------
// lp_delay: enabled register chain
// Holds side data for a fixed number of pipeline stages; shifts on enable.
// ----------------------------------------------------------------------------
module lp_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] stage_q [DEPTH];

  // Shift one stage per enabled cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        stage_q[k] <= stage_q[k-1];
      end
    end
  end

  assign q_o = stage_q[DEPTH-1];

endmodule

### design/lp_div.sv
// ----------------------------------------------------------------------------
// lp_div: pipelined fixed-point divider
// Computes (num << FRAC_BITS) / den truncated toward zero and saturated,
// one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module lp_div import lp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [DIFF_W-1:0]      num_i,
  input  logic signed [DIFF_W-1:0]      den_i,
  output logic                          valid_o,
  output logic signed [COORD_WIDTH-1:0] quot_o
);

  localparam int DW = 2 * COORD_WIDTH;
  localparam int NS = COORD_WIDTH + 1;
  localparam logic [DIFF_W-1:0] HALF = DIFF_W'(1) << (COORD_WIDTH - 1);

  logic [DW-1:0]          rem_d [NS];
  logic [DW-1:0]          rem_q [NS];
  logic [COORD_WIDTH-1:0] quo_d [NS];
  logic [COORD_WIDTH-1:0] quo_q [NS];
  logic [DIFF_W-1:0]      dm_d  [NS];
  logic [DIFF_W-1:0]      dm_q  [NS];
  logic                   neg_d [NS];
  logic                   neg_q [NS];
  logic                   ovf_d [NS];
  logic                   ovf_q [NS];
  logic                   vld_q [NS+1];
  logic signed [COORD_WIDTH-1:0] quot_d, quot_q;

  // Overflow check, quotient bit steps and final saturation.
  always_comb begin
    logic [DIFF_W-1:0] nmag;
    logic [DW-1:0]     trial;
    logic [DIFF_W-1:0] qfull;
    nmag     = num_i[DIFF_W-1] ? DIFF_W'(-num_i) : DIFF_W'(num_i);
    dm_d[0]  = den_i[DIFF_W-1] ? DIFF_W'(-den_i) : DIFF_W'(den_i);
    rem_d[0] = DW'(nmag) << FRAC_BITS;
    ovf_d[0] = {dm_d[0], {COORD_WIDTH{1'b0}}} <= (COORD_WIDTH + DIFF_W)'(rem_d[0]);
    neg_d[0] = num_i[DIFF_W-1] != den_i[DIFF_W-1];
    quo_d[0] = '0;
    for (int k = 1; k < NS; k++) begin
      trial    = DW'(dm_q[k-1]) << (COORD_WIDTH - k);
      dm_d[k]  = dm_q[k-1];
      neg_d[k] = neg_q[k-1];
      ovf_d[k] = ovf_q[k-1];
      if (!ovf_q[k-1] && (trial <= rem_q[k-1])) begin
        rem_d[k] = rem_q[k-1] - trial;
        quo_d[k] = quo_q[k-1] | (COORD_WIDTH'(1) << (COORD_WIDTH - k));
      end else begin
        rem_d[k] = rem_q[k-1];
        quo_d[k] = quo_q[k-1];
      end
    end
    qfull = ovf_q[NS-1] ? (DIFF_W'(1) << COORD_WIDTH) : {1'b0, quo_q[NS-1]};
    if (!neg_q[NS-1]) begin
      quot_d = (qfull >= HALF) ? {1'b0, {(COORD_WIDTH-1){1'b1}}}
                               : qfull[COORD_WIDTH-1:0];
    end else begin
      quot_d = (qfull > HALF) ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                              : COORD_WIDTH'(-qfull);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        dm_q[k]  <= dm_d[k];
        neg_q[k] <= neg_d[k];
        ovf_q[k] <= ovf_d[k];
      end
      quot_q <= quot_d;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= NS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign quot_o  = quot_q;

endmodule

### design/lp_sqrt.sv
// ----------------------------------------------------------------------------
// lp_sqrt: pipelined Euclidean length
// Squares the differences, adds them and takes the integer square root one
// result bit per stage; saturates to the length width.
// ----------------------------------------------------------------------------
module lp_sqrt import lp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [DIFF_W-1:0] dx_i,
  input  logic signed [DIFF_W-1:0] dy_i,
  output logic [LEN_W-1:0]         len_o
);

  localparam int SQ_W  = 2 * DIFF_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int RB    = COORD_WIDTH + 2;
  localparam int TW    = 2 * RB;

  logic [DIFF_W-1:0] mx, my;
  logic [SQ_W-1:0]   sqx_q, sqy_q;
  logic [RB-1:0]     rt_d [RB+1];
  logic [RB-1:0]     rt_q [RB+1];
  logic [TW-1:0]     sr_d [RB+1];
  logic [TW-1:0]     sr_q [RB+1];
  logic [LEN_W-1:0]  len_d, len_q;

  assign mx = dx_i[DIFF_W-1] ? DIFF_W'(-dx_i) : DIFF_W'(dx_i);
  assign my = dy_i[DIFF_W-1] ? DIFF_W'(-dy_i) : DIFF_W'(dy_i);

  // Sum of squares, then one root bit per stage from the top.
  always_comb begin
    logic [TW-1:0] trial;
    rt_d[0] = '0;
    sr_d[0] = TW'(SUM_W'(sqx_q) + SUM_W'(sqy_q));
    for (int k = 1; k <= RB; k++) begin
      trial = (TW'(rt_q[k-1]) << (RB - k + 1)) + (TW'(1) << (2 * (RB - k)));
      if (trial <= sr_q[k-1]) begin
        sr_d[k] = sr_q[k-1] - trial;
        rt_d[k] = rt_q[k-1] | (RB'(1) << (RB - k));
      end else begin
        sr_d[k] = sr_q[k-1];
        rt_d[k] = rt_q[k-1];
      end
    end
    len_d = (rt_q[RB] > RB'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : rt_q[RB][LEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= SQ_W'(mx) * SQ_W'(mx);
      sqy_q <= SQ_W'(my) * SQ_W'(my);
      for (int k = 0; k <= RB; k++) begin
        rt_q[k] <= rt_d[k];
        sr_q[k] <= sr_d[k];
      end
      len_q <= len_d;
    end
  end

  assign len_o = len_q;

endmodule

### design/lp_angle.sv
// ----------------------------------------------------------------------------
// lp_angle: pipelined compass angle
// Normalizes the difference vector, runs a CORDIC vectoring pass with one
// rotation per stage, forms 90 - atan2 with clamping and converts the result
// to fixed-point degrees with one quotient bit per stage.
// ----------------------------------------------------------------------------
module lp_angle import lp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [DIFF_W-1:0]  dx_i,
  input  logic signed [DIFF_W-1:0]  dy_i,
  output logic                      valid_o,
  output logic signed [ANGLE_W-1:0] angle_o
);

  localparam int SH_W  = $clog2(NORM_MSB + 1);
  localparam int NUM_W = Z_W + FRAC_BITS;
  localparam int QB    = ANG_QBITS;
  localparam logic [NUM_W-1:0] HALF_DEG = NUM_W'(NDEG_PER_DEG) >> 1;

  // Arithmetic shift right that truncates toward zero.
  function automatic logic signed [CW-1:0] shr_tz(logic signed [CW-1:0] v, int s);
    logic signed [CW-1:0] r;
    if (v < 0) begin
      r = -((-v) >>> s);
    end else begin
      r = v >>> s;
    end
    return r;
  endfunction

  logic signed [CW-1:0]  ax_q, ay_q, bx_q, by_q, nx_q, ny_q;
  logic [DIFF_W-1:0]     mor_q;
  logic [SH_W-1:0]       sh_d, sh_q;
  logic signed [CW-1:0]  cx_d [CORDIC_STEPS+1];
  logic signed [CW-1:0]  cx_q [CORDIC_STEPS+1];
  logic signed [CW-1:0]  cy_d [CORDIC_STEPS+1];
  logic signed [CW-1:0]  cy_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] cz_d [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] cz_q [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] a_d, a_q;
  logic [NUM_W-1:0]      dr_d [QB+1];
  logic [NUM_W-1:0]      dr_q [QB+1];
  logic [QB-1:0]         dq_d [QB+1];
  logic [QB-1:0]         dq_q [QB+1];
  logic                  ng_d [QB+1];
  logic                  ng_q [QB+1];
  logic signed [ANGLE_W-1:0] angle_d, angle_q;
  logic                  vld_q [ANG_LAT];
  logic [DIFF_W-1:0]     mx, my;

  assign mx = dx_i[DIFF_W-1] ? DIFF_W'(-dx_i) : DIFF_W'(dx_i);
  assign my = dy_i[DIFF_W-1] ? DIFF_W'(-dy_i) : DIFF_W'(dy_i);

  // Shift count that brings the larger magnitude up to the normalization bit.
  always_comb begin
    logic [SH_W-1:0] msb;
    msb = '0;
    for (int j = 0; j < DIFF_W; j++) begin
      if (mor_q[j]) begin
        msb = SH_W'(j);
      end
    end
    sh_d = (mor_q == '0) ? '0 : SH_W'(NORM_MSB) - msb;
  end

  // Quadrant fold, CORDIC rotations and clamped compass angle.
  always_comb begin
    logic signed [CW-1:0] xs, ys;
    logic signed [Z_W-1:0] a;
    if (nx_q < 0) begin
      if (ny_q >= 0) begin
        cx_d[0] = ny_q;
        cy_d[0] = -nx_q;
        cz_d[0] = NDEG_90;
      end else begin
        cx_d[0] = -ny_q;
        cy_d[0] = nx_q;
        cz_d[0] = -NDEG_90;
      end
    end else begin
      cx_d[0] = nx_q;
      cy_d[0] = ny_q;
      cz_d[0] = '0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = shr_tz(cx_q[i], i);
      ys = shr_tz(cy_q[i], i);
      if (cy_q[i] == 0) begin
        cx_d[i+1] = cx_q[i];
        cy_d[i+1] = cy_q[i];
        cz_d[i+1] = cz_q[i];
      end else if (cy_q[i] > 0) begin
        cx_d[i+1] = cx_q[i] + ys;
        cy_d[i+1] = cy_q[i] - xs;
        cz_d[i+1] = cz_q[i] + ATAN_NDEG[i];
      end else begin
        cx_d[i+1] = cx_q[i] - ys;
        cy_d[i+1] = cy_q[i] + xs;
        cz_d[i+1] = cz_q[i] - ATAN_NDEG[i];
      end
    end
    a = NDEG_90 - cz_q[CORDIC_STEPS];
    if (a < -NDEG_90) begin
      a_d = -NDEG_90;
    end else if (a > 3 * NDEG_90) begin
      a_d = 3 * NDEG_90;
    end else begin
      a_d = a;
    end
  end

  // Degrees to fixed point: divide by 1e9 with rounding, one bit per stage.
  always_comb begin
    logic [Z_W-1:0]   m;
    logic [NUM_W-1:0] trial;
    m        = a_q[Z_W-1] ? Z_W'(-a_q) : Z_W'(a_q);
    ng_d[0]  = a_q[Z_W-1];
    dr_d[0]  = (NUM_W'(m) << FRAC_BITS) + HALF_DEG;
    dq_d[0]  = '0;
    for (int j = 1; j <= QB; j++) begin
      trial   = NUM_W'(NDEG_PER_DEG) << (QB - j);
      ng_d[j] = ng_q[j-1];
      if (trial <= dr_q[j-1]) begin
        dr_d[j] = dr_q[j-1] - trial;
        dq_d[j] = dq_q[j-1] | (QB'(1) << (QB - j));
      end else begin
        dr_d[j] = dr_q[j-1];
        dq_d[j] = dq_q[j-1];
      end
    end
    angle_d = ng_q[QB] ? -ANGLE_W'(dq_q[QB]) : ANGLE_W'(dq_q[QB]);
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q  <= CW'(dx_i);
      ay_q  <= CW'(dy_i);
      mor_q <= mx | my;
      bx_q  <= ax_q;
      by_q  <= ay_q;
      sh_q  <= sh_d;
      nx_q  <= bx_q <<< sh_q;
      ny_q  <= by_q <<< sh_q;
      for (int i = 0; i <= CORDIC_STEPS; i++) begin
        cx_q[i] <= cx_d[i];
        cy_q[i] <= cy_d[i];
        cz_q[i] <= cz_d[i];
      end
      a_q <= a_d;
      for (int j = 0; j <= QB; j++) begin
        dr_q[j] <= dr_d[j];
        dq_q[j] <= dq_d[j];
        ng_q[j] <= ng_d[j];
      end
      angle_q <= angle_d;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ANG_LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < ANG_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[ANG_LAT-1];
  assign angle_o = angle_q;

endmodule

### design/line_parameters.sv
// ----------------------------------------------------------------------------
// line_parameters: slope, intercept, length and compass angle of a line
// Two-point or point-slope mode, signed Q16.16 coordinates, fully pipelined.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+-------------------------------------
//   input   | in_valid_i / in_ready_o | first_x/y, second_x/y, given_slope
//   output  | out_valid_o/out_ready_i | slope, intercept, end_x/y, length,
//           |                         | angle, status
//
// One item enters per cycle while no result waits untaken; each result passes the
// input register, the 34-stage divider, the product and intercept stages,
// then the 65-stage angle unit (CORDIC plus degree conversion), which sets
// the depth; the length unit runs beside it and is delayed to match.
// The output register is the last stage. The whole pipeline advances unless
// a result waits untaken, so a stall holds every item in place.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module line_parameters import lp_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  input  logic signed [COORD_WIDTH-1:0] given_slope_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] slope_out_o,
  output logic signed [COORD_WIDTH-1:0] intercept_out_o,
  output logic signed [COORD_WIDTH-1:0] end_x_o,
  output logic signed [COORD_WIDTH-1:0] end_y_o,
  output logic [LEN_W-1:0]              length_out_o,
  output logic signed [ANGLE_W-1:0]     angle_out_o,
  output logic                          status_o
);

  localparam int PW     = 2 * COORD_WIDTH;
  localparam int PM_W   = COORD_WIDTH + 2;
  localparam int RAW_W  = PM_W + 2;
  localparam int LEN_DLY = ANG_LAT - LEN_LAT;
  localparam logic [PW-1:0] CAP = PW'(1) << (COORD_WIDTH + 1);
  localparam logic signed [RAW_W-1:0] SMAX = RAW_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [RAW_W-1:0] SMIN = -(RAW_W'(1) << (COORD_WIDTH - 1));

  logic       en;
  lp_side_t   in_d, in_q, side_div, mul_side_q;
  logic       in_v_q, div_v, mul_v_q, ic_v_q, ang_v;
  logic signed [DIFF_W-1:0] num, den, dx, dy;
  logic signed [COORD_WIDTH-1:0] quot, slope_sel;
  logic [COORD_WIDTH-1:0] smag, xmag;
  logic signed [COORD_WIDTH-1:0] slope_q;
  logic [PW-1:0] prod_q;
  logic          pneg_q;
  lp_res_t       res_d, res_q, res_out;
  logic signed [COORD_WIDTH-1:0] ic_x1_q, ic_y1_q;
  logic [LEN_W-1:0] len_raw;

  // The pipeline moves unless a finished result is still waiting.
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  // Input register with mode decode.
  always_comb begin
    in_d.x1     = first_x_i;
    in_d.y1     = first_y_i;
    in_d.x2     = second_x_i;
    in_d.y2     = second_y_i;
    in_d.gs     = given_slope_i;
    in_d.pslope = (second_x_i == '0) && (second_y_i == '0);
    in_d.vert   = !in_d.pslope && (second_x_i == first_x_i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_d;
    end
  end

  assign num = DIFF_W'(in_q.y2) - DIFF_W'(in_q.y1);
  assign den = DIFF_W'(in_q.x2) - DIFF_W'(in_q.x1);

  lp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .num_i   (num),
    .den_i   (den),
    .valid_o (div_v),
    .quot_o  (quot)
  );

  lp_delay #(.WIDTH($bits(lp_side_t)), .DEPTH(DIV_LAT)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (in_q),
    .q_o   (side_div)
  );

  // Slope selection and slope times first x.
  always_comb begin
    if (side_div.pslope) begin
      slope_sel = side_div.gs;
    end else if (side_div.vert) begin
      slope_sel = '0;
    end else begin
      slope_sel = quot;
    end
    smag = slope_sel[COORD_WIDTH-1] ? COORD_WIDTH'(-slope_sel) : COORD_WIDTH'(slope_sel);
    xmag = side_div.x1[COORD_WIDTH-1] ? COORD_WIDTH'(-side_div.x1)
                                      : COORD_WIDTH'(side_div.x1);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      slope_q    <= slope_sel;
      prod_q     <= PW'(smag) * PW'(xmag);
      pneg_q     <= slope_sel[COORD_WIDTH-1] != side_div.x1[COORD_WIDTH-1];
      mul_side_q <= side_div;
    end
  end

  // Intercept: y1 minus the truncated product, saturated; end point chosen.
  always_comb begin
    logic [PW-1:0]            psh;
    logic [PM_W-1:0]          pm;
    logic signed [PM_W:0]     pv;
    logic signed [RAW_W-1:0]  raw;
    logic signed [COORD_WIDTH-1:0] sat;
    psh = prod_q >> FRAC_BITS;
    pm  = (psh > CAP) ? CAP[PM_W-1:0] : psh[PM_W-1:0];
    pv  = pneg_q ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
    raw = RAW_W'(mul_side_q.y1) - RAW_W'(pv);
    if (raw > SMAX) begin
      sat = SMAX[COORD_WIDTH-1:0];
    end else if (raw < SMIN) begin
      sat = SMIN[COORD_WIDTH-1:0];
    end else begin
      sat = raw[COORD_WIDTH-1:0];
    end
    res_d.slope = slope_q;
    res_d.icpt  = mul_side_q.vert ? '0 : sat;
    res_d.end_x = mul_side_q.pslope ? '0 : mul_side_q.x2;
    res_d.end_y = mul_side_q.pslope ? sat : mul_side_q.y2;
    res_d.vert  = mul_side_q.vert;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q   <= res_d;
      ic_x1_q <= mul_side_q.x1;
      ic_y1_q <= mul_side_q.y1;
    end
  end

  // Valid bits of the stages outside the units.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
      ic_v_q  <= 1'b0;
    end else if (en) begin
      in_v_q  <= in_valid_i;
      mul_v_q <= div_v;
      ic_v_q  <= mul_v_q;
    end
  end

  // Difference vector of the line as used.
  assign dx = DIFF_W'(res_q.end_x) - DIFF_W'(ic_x1_q);
  assign dy = DIFF_W'(res_q.end_y) - DIFF_W'(ic_y1_q);

  lp_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .dx_i  (dx),
    .dy_i  (dy),
    .len_o (len_raw)
  );

  lp_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ic_v_q),
    .dx_i    (dx),
    .dy_i    (dy),
    .valid_o (ang_v),
    .angle_o (angle_out_o)
  );

  lp_delay #(.WIDTH(LEN_W), .DEPTH(LEN_DLY)) u_len_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (len_raw),
    .q_o   (length_out_o)
  );

  lp_delay #(.WIDTH($bits(lp_res_t)), .DEPTH(ANG_LAT)) u_res_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (res_q),
    .q_o   (res_out)
  );

  assign out_valid_o     = ang_v;
  assign slope_out_o     = res_out.slope;
  assign intercept_out_o = res_out.icpt;
  assign end_x_o         = res_out.end_x;
  assign end_y_o         = res_out.end_y;
  assign status_o        = res_out.vert;

`ifndef NO_ASSERTIONS
  // A vertical line reports zero slope and intercept.
  a_vert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> slope_out_o == '0 && intercept_out_o == '0)
    else $error("vertical result with nonzero slope or intercept");

  // The compass angle stays within -90 to 270 degrees.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_out_o >= -(ANGLE_W'(90) <<< FRAC_BITS) &&
                    angle_out_o <= (ANGLE_W'(270) <<< FRAC_BITS))
    else $error("angle outside -90..270 degrees");

  // Coincident points give zero length and an angle of exactly 90 degrees.
  a_coincident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_out_o == '0 |-> angle_out_o == (ANGLE_W'(90) <<< FRAC_BITS))
    else $error("zero length with angle other than 90 degrees");
`endif

endmodule
